[hdl/smav_pkg.sv]
package smav_pkg;

  // Fixed field widths of the poll and result transactions.
  localparam int SAMPLE_BITS = 16;
  localparam int TIME_W      = 32;
  localparam int ID_W        = 7;
  localparam int LOG_SLOT_W  = 7;
  localparam int LEN_CFG_W   = 8;

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_FILTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_ENABLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_ID      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_ID       = 3'd7;

  // Register reset values.
  localparam logic [TIME_W-1:0]    PERIOD_RST = 32'd100;
  localparam logic [LEN_CFG_W-1:0] LENGTH_RST = 8'd10;
  localparam logic [ID_W-1:0]      FRONT_ID_RST = 7'd90;
  localparam logic [ID_W-1:0]      REAR_ID_RST  = 7'd91;

  // Defaults for the top level parameters.
  localparam int WINDOW_MAX_DEF = 128;
  localparam int LOG_DEPTH_DEF  = 100;

  typedef struct packed {
    logic [TIME_W-1:0]             current_time;
    logic signed [SAMPLE_BITS-1:0] front_sample;
    logic signed [SAMPLE_BITS-1:0] rear_sample;
    logic [ID_W-1:0]               front_id_read;
    logic [ID_W-1:0]               rear_id_read;
  } smav_in_t;

  typedef struct packed {
    logic                          sample_taken;
    logic                          front_ok;
    logic                          rear_ok;
    logic signed [SAMPLE_BITS-1:0] front_value;
    logic                          front_new;
    logic signed [SAMPLE_BITS-1:0] rear_value;
    logic                          rear_new;
    logic                          log_write;
    logic [LOG_SLOT_W-1:0]         log_slot;
    logic                          log_full;
  } smav_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic eval;
    logic div_load;
    logic out_load;
  } smav_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } smav_stat_t;

endpackage

[hdl/smav_div.sv]
module smav_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] rem_next;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic             q_bit;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial    = {rem, quo[DVD_W-1]};
    q_bit    = (trial >= {1'b0, divisor});
    rem_next = q_bit ? DVS_W'(trial - {1'b0, divisor}) : DVS_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DVD_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      quo <= {quo[DVD_W-2:0], q_bit};
      rem <= rem_next;
    end
  end

  assign done     = (cnt == '0);
  assign quotient = quo;

endmodule

[hdl/smav_dp.sv]
module smav_dp #(
  parameter int WINDOW_MAX = smav_pkg::WINDOW_MAX_DEF,
  parameter int LOG_DEPTH  = smav_pkg::LOG_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [smav_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smav_pkg::CFG_W-1:0]     cfg_data,
  input  smav_pkg::smav_in_t             in_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output smav_pkg::smav_out_t            out_data,
  input  smav_pkg::smav_cmd_t            cmd,
  output smav_pkg::smav_stat_t           stat
);

  import smav_pkg::*;

  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int POS_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
  localparam int LOG_CW = $clog2(LOG_DEPTH + 1);

  // Configuration registers.
  logic [TIME_W-1:0]    sample_period;
  logic [LEN_CFG_W-1:0] filter_length;
  logic                 front_enable;
  logic                 rear_enable;
  logic                 front_filter_enable;
  logic                 log_enable;
  logic [ID_W-1:0]      front_id;
  logic [ID_W-1:0]      rear_id;

  // Block state.
  logic signed [SAMPLE_BITS-1:0] win_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [POS_W-1:0]              win_pos;
  logic                          win_filled;
  logic signed [SUM_W-1:0]       win_sum;
  logic [TIME_W-1:0]             last_time;
  logic signed [SAMPLE_BITS-1:0] front_hold;
  logic signed [SAMPLE_BITS-1:0] rear_hold;
  logic [LOG_CW-1:0]             log_count;

  smav_in_t in_reg;
  logic     sum_neg;

  // Per-transaction result flags.
  logic                  res_taken;
  logic                  res_front_ok;
  logic                  res_rear_ok;
  logic                  res_front_new;
  logic                  res_rear_new;
  logic                  res_log_write;
  logic [LOG_SLOT_W-1:0] res_log_slot;

  // Evaluation terms.
  logic [LEN_W-1:0]              len;
  logic [TIME_W-1:0]             elapsed;
  logic [TIME_W-1:0]             period_eff;
  logic                          taken;
  logic                          front_ok;
  logic                          rear_ok;
  logic                          front_upd;
  logic                          filt_upd;
  logic                          rear_upd;
  logic                          log_full_now;
  logic                          log_wr;
  logic signed [SAMPLE_BITS-1:0] old_entry;
  logic signed [SUM_W-1:0]       sum_new;
  logic [SUM_W-1:0]              sum_mag;
  logic [LEN_W-1:0]              pos_inc;
  logic                          pos_wrap;
  logic [POS_W-1:0]              pos_next;
  logic [LOG_CW-1:0]             log_count_inc;
  logic                          div_done;
  logic [SUM_W-1:0]              quo_mag;
  logic [SUM_W-1:0]              quo_signed;

  always_comb begin
    if (filter_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(filter_length) > WINDOW_MAX) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(filter_length);
    end
  end

  always_comb begin
    elapsed      = in_reg.current_time - last_time;
    period_eff   = (sample_period == '0) ? TIME_W'(1) : sample_period;
    taken        = (elapsed >= period_eff);
    front_ok     = !front_enable || (in_reg.front_id_read == front_id);
    rear_ok      = !rear_enable || (in_reg.rear_id_read == rear_id);
    front_upd    = taken && front_enable && front_ok;
    filt_upd     = front_upd && front_filter_enable;
    rear_upd     = taken && rear_enable && rear_ok;
    log_full_now = (log_count == LOG_CW'(LOG_DEPTH));
    log_wr       = rear_upd && log_enable && !log_full_now;
    log_count_inc = log_count + LOG_CW'(1);

    // Entries past the fill point have never been written since the clear.
    old_entry = win_filled ? rd_data : '0;
    sum_new   = win_sum + SUM_W'(in_reg.front_sample) - SUM_W'(old_entry);
    sum_mag   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
    pos_inc   = LEN_W'(win_pos) + LEN_W'(1);
    pos_wrap  = (pos_inc >= len);
    pos_next  = pos_wrap ? '0 : POS_W'(pos_inc);

    quo_signed = sum_neg ? SUM_W'(-quo_mag) : quo_mag;
  end

  smav_div #(
    .DVD_W (SUM_W),
    .DVS_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.eval && filt_upd),
    .dividend (sum_mag),
    .divisor  (len),
    .done     (div_done),
    .quotient (quo_mag)
  );

  // Window memory: read at accept, written at evaluation.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data <= win_mem[win_pos];
    end
    if (cmd.eval && filt_upd) begin
      win_mem[win_pos] <= in_reg.front_sample;
    end
  end

  // Configuration and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period       <= PERIOD_RST;
      filter_length       <= LENGTH_RST;
      front_enable        <= 1'b0;
      rear_enable         <= 1'b0;
      front_filter_enable <= 1'b0;
      log_enable          <= 1'b0;
      front_id            <= FRONT_ID_RST;
      rear_id             <= REAR_ID_RST;
      win_pos             <= '0;
      win_filled          <= 1'b0;
      win_sum             <= '0;
      last_time           <= '0;
      front_hold          <= '0;
      rear_hold           <= '0;
      log_count           <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[TIME_W-1:0];
        REG_FILTER_LENGTH: begin
          filter_length <= cfg_data[LEN_CFG_W-1:0];
          win_pos       <= '0;
          win_filled    <= 1'b0;
          win_sum       <= '0;
        end
        REG_FRONT_ENABLE:  front_enable        <= cfg_data[0];
        REG_REAR_ENABLE:   rear_enable         <= cfg_data[0];
        REG_FRONT_FILTER:  front_filter_enable <= cfg_data[0];
        REG_LOG_ENABLE:    log_enable          <= cfg_data[0];
        REG_FRONT_ID:      front_id            <= cfg_data[ID_W-1:0];
        REG_REAR_ID:       rear_id             <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end else if (cmd.eval) begin
      if (taken) begin
        last_time <= in_reg.current_time;
      end
      if (front_upd && !front_filter_enable) begin
        front_hold <= in_reg.front_sample;
      end
      if (filt_upd) begin
        win_sum <= sum_new;
        win_pos <= pos_next;
        if (pos_wrap) begin
          win_filled <= 1'b1;
        end
      end
      if (rear_upd) begin
        rear_hold <= in_reg.rear_sample;
        if (log_enable) begin
          if (log_full_now) begin
            log_enable <= 1'b0;
          end else begin
            log_count <= log_count_inc;
            if (log_count_inc == LOG_CW'(LOG_DEPTH)) begin
              log_enable <= 1'b0;
            end
          end
        end
      end
    end else if (cmd.div_load) begin
      front_hold <= quo_signed[SAMPLE_BITS-1:0];
    end
  end

  // Captured transaction and its flags.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_reg <= in_data;
    end
    if (cmd.eval) begin
      sum_neg       <= sum_new[SUM_W-1];
      res_taken     <= taken;
      res_front_ok  <= front_ok;
      res_rear_ok   <= rear_ok;
      res_front_new <= front_upd;
      res_rear_new  <= rear_upd;
      res_log_write <= log_wr;
      res_log_slot  <= log_wr ? LOG_SLOT_W'(log_count) : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.sample_taken <= res_taken;
      out_data.front_ok     <= res_front_ok;
      out_data.rear_ok      <= res_rear_ok;
      out_data.front_value  <= front_hold;
      out_data.front_new    <= res_front_new;
      out_data.rear_value   <= rear_hold;
      out_data.rear_new     <= res_rear_new;
      out_data.log_write    <= res_log_write;
      out_data.log_slot     <= res_log_slot;
      out_data.log_full     <= log_full_now;
    end
  end

  assign stat.need_div = filt_upd;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

[hdl/smav_ctrl.sv]
module smav_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output smav_pkg::smav_cmd_t  cmd,
  input  smav_pkg::smav_stat_t stat
);

  import smav_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.need_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_load = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

[hdl/sampled_dual_sensor_moving_average_unit.sv]
// Dual sensor poller with a boxcar moving average on the front channel. Each input
// transaction is one poll (time, two signed temperature samples, two read-back bus ids)
// and produces exactly one output transaction. A sample is taken when the elapsed time
// since the last sample, modulo 2^32, reaches sample_period (a zero period acts as one).
// The block works on one poll at a time: it accepts a poll, evaluates it and, when the
// filtered front value must be recomputed, runs a serial divider that retires one
// quotient bit at a time over the SUM_W bits of the window sum, SUM_W being the width
// of the window sum, and then loads the quotient. Last, it hands the result to the
// output register once that register is free.
// A finished result waits in an output register, so the next poll is taken as soon as
// the current one has been handed to that register.
// Write configuration registers only while no poll is in flight. Writing filter_length
// empties the averaging window at once; no clearing pass is needed after reset.
module sampled_dual_sensor_moving_average_unit #(
  parameter int WINDOW_MAX = smav_pkg::WINDOW_MAX_DEF,
  parameter int LOG_DEPTH  = smav_pkg::LOG_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  smav_pkg::smav_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output smav_pkg::smav_out_t            out_data,
  input  logic                           cfg_write,
  input  logic [smav_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smav_pkg::CFG_W-1:0]     cfg_data
);

  import smav_pkg::*;

  // Commands flow from the sequencer to the datapath, status flows back.
  smav_cmd_t  cmd;
  smav_stat_t stat;

  // The sequencer steps each poll through accept, evaluate, an optional divide and
  // the handoff to the output register.
  smav_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the configuration registers, the window memory, the running
  // sum, the log counter, the held sensor values and the output register.
  smav_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .LOG_DEPTH  (LOG_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[dv/testbench.sv]
module testbench;
  import smav_pkg::*;

  localparam int WINDOW_MAX   = WINDOW_MAX_DEF;
  localparam int LOG_DEPTH    = LOG_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 12;
  localparam int PHASE_POLLS  = 75;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  smav_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  smav_out_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  sampled_dual_sensor_moving_average_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Register copies kept by the poll predictor.
  logic [TIME_W-1:0]    period_r;
  logic [LEN_CFG_W-1:0] length_r;
  logic                 front_en, rear_en, filter_en, log_en;
  logic [ID_W-1:0]      fid_r, rid_r;

  // Predictor state: averaging window, sample timing, held values, log fill.
  logic signed [SAMPLE_BITS-1:0] window_mem [WINDOW_MAX];
  int                            window_ptr;
  int                            window_total;
  logic [TIME_W-1:0]             last_time;
  logic signed [SAMPLE_BITS-1:0] front_hold_v, rear_hold_v;
  int                            logged;

  smav_out_t expected_results [$];
  int        mismatch_count = 0;

  // Flow control modes: a calm side never idles, so back-to-back stretches occur.
  logic sender_calm   = 1'b0;
  logic receiver_calm = 1'b0;
  logic hold_off      = 1'b0;

  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
    smav_in_t             poll;
    logic                 typed;
    smav_out_t            result;
  } stim_row_t;

  stim_row_t directed [$];

  function automatic int draw_wait(logic calm);
    return calm ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WINDOW_MAX; i++) window_mem[i] = '0;
    window_ptr   = 0;
    window_total = 0;
  endfunction

  // Some writes carry junk above the register width, which the block must drop.
  function automatic logic [CFG_W-1:0] with_noise(logic [CFG_W-1:0] v, logic [CFG_W-1:0] mask);
    if ($urandom_range(0, 3) == 0) return (v & mask) | ($urandom() & ~mask);
    return v & mask;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'shFFFF;
      3: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic stim_row_t poll_row(logic [TIME_W-1:0] t, int fs, int rs, int fid, int rid);
    stim_row_t row;
    row = '0;
    row.kind = ROW_POLL;
    row.poll.current_time  = t;
    row.poll.front_sample  = 16'(fs);
    row.poll.rear_sample   = 16'(rs);
    row.poll.front_id_read = 7'(fid);
    row.poll.rear_id_read  = 7'(rid);
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_CFG;
    row.index = idx;
    row.value = v;
    return row;
  endfunction

  // A directed poll whose result is typed in by hand.
  function automatic stim_row_t checked(stim_row_t row, int taken, int fok, int rok, int fv,
                                        int fnew, int rv, int rnew, int lw, int slot, int full);
    row.typed               = 1'b1;
    row.result.sample_taken = 1'(taken);
    row.result.front_ok     = 1'(fok);
    row.result.rear_ok      = 1'(rok);
    row.result.front_value  = 16'(fv);
    row.result.front_new    = 1'(fnew);
    row.result.rear_value   = 16'(rv);
    row.result.rear_new     = 1'(rnew);
    row.result.log_write    = 1'(lw);
    row.result.log_slot     = 7'(slot);
    row.result.log_full     = 1'(full);
    return row;
  endfunction

  // Works out the result of one poll and advances the predictor state.
  function automatic smav_out_t predict_poll(smav_in_t p);
    smav_out_t         r;
    logic [TIME_W-1:0] per;
    int                len;
    r   = '0;
    per = (period_r == '0) ? 32'd1 : period_r;
    r.front_ok     = !front_en || (p.front_id_read == fid_r);
    r.rear_ok      = !rear_en || (p.rear_id_read == rid_r);
    r.sample_taken = ((p.current_time - last_time) >= per);
    if (r.sample_taken) begin
      if (front_en && r.front_ok) begin
        if (filter_en) begin
          len = (length_r == '0) ? 1 : int'(length_r);
          if (len > WINDOW_MAX) len = WINDOW_MAX;
          if (window_ptr >= len) window_ptr = 0;
          window_total += int'(p.front_sample) - int'(window_mem[window_ptr]);
          window_mem[window_ptr] = p.front_sample;
          // Integer division truncates toward zero, as the block must.
          front_hold_v = 16'(window_total / len);
          window_ptr++;
          if (window_ptr >= len) window_ptr = 0;
        end else begin
          front_hold_v = p.front_sample;
        end
        r.front_new = 1'b1;
      end
      if (rear_en && r.rear_ok) begin
        rear_hold_v = p.rear_sample;
        r.rear_new  = 1'b1;
        if (log_en) begin
          if (logged < LOG_DEPTH) begin
            r.log_write = 1'b1;
            r.log_slot  = 7'(logged);
            logged++;
            if (logged >= LOG_DEPTH) log_en = 1'b0;
          end else begin
            log_en = 1'b0;
          end
        end
      end
      last_time = p.current_time;
    end
    r.front_value = front_hold_v;
    r.rear_value  = rear_hold_v;
    r.log_full    = (logged >= LOG_DEPTH);
    return r;
  endfunction

  // Leaves cfg_write high; the caller lowers it after the last write of a batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_SAMPLE_PERIOD: period_r = v;
      REG_FILTER_LENGTH: begin
        length_r = v[LEN_CFG_W-1:0];
        clear_window();
      end
      REG_FRONT_ENABLE:  front_en  = v[0];
      REG_REAR_ENABLE:   rear_en   = v[0];
      REG_FRONT_FILTER:  filter_en = v[0];
      REG_LOG_ENABLE:    log_en    = v[0];
      REG_FRONT_ID:      fid_r     = v[ID_W-1:0];
      REG_REAR_ID:       rid_r     = v[ID_W-1:0];
      default: ;
    endcase
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  // Stops offering polls until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Offers one poll transaction; valid stays high after acceptance so that a
  // following poll with no gap keeps it asserted without a glitch.
  task automatic send_poll(smav_in_t p, logic typed, smav_out_t typed_result);
    int        gap;
    smav_out_t predicted;
    gap = draw_wait(sender_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_poll(p);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(smav_out_t got);
    smav_out_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: result %h arrived with nothing expected", $time, got);
    end else begin
      want = expected_results.pop_front();
      check_field("sample_taken", want.sample_taken, got.sample_taken);
      check_field("front_ok", want.front_ok, got.front_ok);
      check_field("rear_ok", want.rear_ok, got.rear_ok);
      check_field("front_value", want.front_value, got.front_value);
      check_field("front_new", want.front_new, got.front_new);
      check_field("rear_value", want.rear_value, got.rear_value);
      check_field("rear_new", want.rear_new, got.rear_new);
      check_field("log_write", want.log_write, got.log_write);
      check_field("log_slot", want.log_slot, got.log_slot);
      check_field("log_full", want.log_full, got.log_full);
    end
  endtask

  // Result side: random stalls per transaction, with one long hold-off on request
  // so that the block backs up and stalls its input.
  initial begin : result_sink
    int wait_cycles;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      wait_cycles = hold_off ? HOLD_CYCLES : draw_wait(receiver_calm);
      hold_off    = 1'b0;
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result(out_data);
    end
  end

  initial begin : stimulus
    logic              cfg_open;
    smav_in_t          poll;
    logic [TIME_W-1:0] per, step, period_pick;
    logic [CFG_W-1:0]  len_pick;

    // Predictor starts from the reset values of the block.
    period_r     = PERIOD_RST;
    length_r     = LENGTH_RST;
    front_en     = 1'b0;
    rear_en      = 1'b0;
    filter_en    = 1'b0;
    log_en       = 1'b0;
    fid_r        = FRONT_ID_RST;
    rid_r        = REAR_ID_RST;
    clear_window();
    last_time    = '0;
    front_hold_v = '0;
    rear_hold_v  = '0;
    logged       = 0;

    // Sensors off: samples are taken on time (including across the 32-bit wrap),
    // but nothing is updated and both links read as good.
    directed.push_back(checked(poll_row(0, 1234, -5, 0, 127), 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(checked(poll_row(100, -1234, 5, 90, 91), 1, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(checked(poll_row(99, 0, 0, 90, 91), 1, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    // A zero period behaves as one; raw values at the sample extremes.
    directed.push_back(cfg_row(REG_SAMPLE_PERIOD, 32'd0));
    directed.push_back(cfg_row(REG_FRONT_ENABLE, 32'd1));
    directed.push_back(cfg_row(REG_REAR_ENABLE, 32'd1));
    directed.push_back(checked(poll_row(100, 32767, -32768, 90, 91),
                               1, 1, 1, 32767, 1, -32768, 1, 0, 0, 0));
    directed.push_back(checked(poll_row(100, 0, 0, 90, 91),
                               0, 1, 1, 32767, 0, -32768, 0, 0, 0, 0));
    // Wrong read-back ids: both links fail and the held values stay.
    directed.push_back(checked(poll_row(101, 5, 5, 127, 0),
                               1, 0, 0, 32767, 0, -32768, 0, 0, 0, 0));
    // Length zero acts as one; a length above the window saturates.
    directed.push_back(cfg_row(REG_FRONT_FILTER, 32'd1));
    directed.push_back(cfg_row(REG_FILTER_LENGTH, 32'd0));
    directed.push_back(checked(poll_row(102, -32768, 100, 90, 91),
                               1, 1, 1, -32768, 1, 100, 1, 0, 0, 0));
    directed.push_back(cfg_row(REG_FILTER_LENGTH, 32'd200));
    directed.push_back(checked(poll_row(103, -1, -1, 90, 91), 1, 1, 1, 0, 1, -1, 1, 0, 0, 0));
    directed.push_back(poll_row(104, 32767, 32767, 90, 91));
    // Short window that wraps, negative means truncated toward zero, logging.
    directed.push_back(cfg_row(REG_FILTER_LENGTH, 32'd3));
    directed.push_back(cfg_row(REG_LOG_ENABLE, 32'd1));
    directed.push_back(cfg_row(REG_FRONT_ID, 32'd0));
    directed.push_back(cfg_row(REG_REAR_ID, 32'd127));
    directed.push_back(checked(poll_row(105, -5, 7, 0, 127), 1, 1, 1, -1, 1, 7, 1, 1, 0, 0));
    directed.push_back(poll_row(106, -5, 8, 0, 127));
    directed.push_back(poll_row(107, 3, -9, 0, 127));
    directed.push_back(poll_row(108, 20, 1, 0, 127));
    directed.push_back(poll_row(108, 1, 1, 0, 127));
    // Largest period: only an elapsed time of all ones takes a sample.
    directed.push_back(cfg_row(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF));
    directed.push_back(cfg_row(REG_FRONT_FILTER, 32'd0));
    directed.push_back(poll_row(107, -2, -3, 0, 127));
    directed.push_back(poll_row(200, 9, 9, 0, 127));
    directed.push_back(cfg_row(REG_SAMPLE_PERIOD, 32'd1));
    directed.push_back(cfg_row(REG_FRONT_ENABLE, 32'd0));
    directed.push_back(cfg_row(REG_REAR_ENABLE, 32'd0));
    directed.push_back(cfg_row(REG_LOG_ENABLE, 32'd0));
    directed.push_back(poll_row(300, 1, 1, 127, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Registers change only once the block has handed back every result.
    cfg_open = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          drain();
          cfg_open = 1'b1;
        end
        write_reg(directed[i].index, directed[i].value);
      end else begin
        if (cfg_open) begin
          cfg_write <= 1'b0;
          cfg_open   = 1'b0;
        end
        send_poll(directed[i].poll, directed[i].typed, directed[i].result);
      end
    end

    // Random phases. The first one runs a slow filtered setting with the sender
    // never idling while the receiver holds off; the second turns logging on.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      sender_calm = (ph == 0) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       period_pick = 32'd0;
        1:       period_pick = 32'd1;
        2:       period_pick = 32'hFFFF_FFFF;
        3:       period_pick = $urandom();
        default: period_pick = $urandom_range(2, 40);
      endcase
      if (ph < 2) period_pick = $urandom_range(1, 5);
      write_reg(REG_SAMPLE_PERIOD, period_pick);
      if (ph < 2 || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       len_pick = 32'd0;
          1:       len_pick = 32'd128;
          2:       len_pick = $urandom_range(129, 255);
          3:       len_pick = $urandom_range(9, 127);
          default: len_pick = $urandom_range(1, 8);
        endcase
        if (ph == 0) len_pick = $urandom_range(1, 8);
        write_reg(REG_FILTER_LENGTH, with_noise(len_pick, 32'hFF));
      end
      write_reg(REG_FRONT_ENABLE, with_noise(32'(ph < 2 || $urandom_range(0, 3) != 0), 32'h1));
      write_reg(REG_REAR_ENABLE, with_noise(32'(ph < 2 || $urandom_range(0, 3) != 0), 32'h1));
      write_reg(REG_FRONT_FILTER, with_noise(32'(ph == 0 || $urandom_range(0, 4) >= 2), 32'h1));
      write_reg(REG_LOG_ENABLE, with_noise(32'(ph == 1 || $urandom_range(0, 1) == 1), 32'h1));
      if ($urandom_range(0, 1) == 1) write_reg(REG_FRONT_ID, with_noise($urandom(), 32'h7F));
      if ($urandom_range(0, 1) == 1) write_reg(REG_REAR_ID, with_noise($urandom(), 32'h7F));
      cfg_write <= 1'b0;
      if (ph == 0) hold_off = 1'b1;

      for (int n = 0; n < PHASE_POLLS; n++) begin
        if (ph != 0) begin
          if ($urandom_range(0, 49) == 0) drain();
          if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
        end
        // Time steps cluster around the period, measured from the last sample,
        // so that most polls land right at or past the sampling threshold.
        per = (period_r == '0) ? 32'd1 : period_r;
        case ($urandom_range(0, 9))
          0:       step = per - 32'd1;
          1, 2:    step = per;
          3:       step = $urandom();
          4:       step = $urandom_range(0, 3);
          default: step = per + $urandom_range(0, 7);
        endcase
        poll.current_time  = last_time + step;
        poll.front_sample  = pick_sample();
        poll.rear_sample   = pick_sample();
        poll.front_id_read = ($urandom_range(0, 6) == 0) ? 7'($urandom()) : fid_r;
        poll.rear_id_read  = ($urandom_range(0, 6) == 0) ? 7'($urandom()) : rid_r;
        send_poll(poll, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
